[sv/rar_pkg.sv]
// Shared types and command codes for the rational arithmetic reducer.
package rar_pkg;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_SUB = 2'd1;
   localparam logic [1:0] CMD_MUL = 2'd2;
   localparam logic [1:0] CMD_DIV = 2'd3;

   localparam int NUM_OUT_WIDTH = 33;
   localparam int DEN_OUT_WIDTH = 32;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

endpackage

[sv/rar_cell.sv]
// One bit slice of the shift-subtract divider row.
module rar_cell (
   input  logic                 clock,
   input  rar_pkg::div_ctl_type ctl,
   input  logic                 load_bit,
   input  logic                 r_lo,
   input  logic                 q_lo,
   input  logic                 d_bit,
   input  logic                 borrow_in,
   input  logic                 sub,
   output logic                 r_bit,
   output logic                 q_bit,
   output logic                 borrow_out
);

   logic r_ff;
   logic q_ff;
   logic r_in;

   // trial bit is the remainder bit shifted up from the neighbor below
   assign borrow_out = (~r_lo & d_bit) | (~(r_lo ^ d_bit) & borrow_in);
   assign r_in       = sub ? (r_lo ^ d_bit ^ borrow_in) : r_lo;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         r_ff <= 1'b0;
         q_ff <= load_bit;
      end else if (ctl.step) begin
         r_ff <= r_in;
         q_ff <= q_lo;
      end
   end

   assign r_bit = r_ff;
   assign q_bit = q_ff;

endmodule

[sv/rar_div_row.sv]
// Row of divider cells: restoring division, one quotient bit per step.
module rar_div_row #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  rar_pkg::div_ctl_type ctl,
   input  logic [WIDTH-1:0]     dividend,
   input  logic [WIDTH-1:0]     divisor,
   output logic [WIDTH-1:0]     quotient
);

   logic [WIDTH-1:0] r;
   logic [WIDTH-1:0] q;
   logic [WIDTH:0]   bw;
   logic             sub;

   assign bw[0] = 1'b0;
   // top remainder bit shifted out means the trial value exceeds any divisor
   assign sub   = r[WIDTH-1] | ~bw[WIDTH];

   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      logic r_lo;
      logic q_lo;
      if (i == 0) begin : g_first
         assign r_lo = q[WIDTH-1];
         assign q_lo = sub;
      end else begin : g_rest
         assign r_lo = r[i-1];
         assign q_lo = q[i-1];
      end
      rar_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .load_bit   (dividend[i]),
         .r_lo       (r_lo),
         .q_lo       (q_lo),
         .d_bit      (divisor[i]),
         .borrow_in  (bw[i]),
         .sub        (sub),
         .r_bit      (r[i]),
         .q_bit      (q[i]),
         .borrow_out (bw[i+1])
      );
   end

   assign quotient = q;

endmodule

[sv/rational_arith_reduce.sv]
// Top level: exact add/sub/mul/div of two fractions, reduced to lowest terms.
//
// Input stream req_*: one item per operation (command and two fractions).
// Result stream rsp_*: one item per input item, in order: reduced numerator
// carrying the sign, positive denominator, and a zero-divide flag in tuser.
// A zero denominator or division by a zero fraction flags the error and
// returns 0/1; a zero result returns 0/1 without the flag.
// One item is worked at a time. It registers the operands, then forms the
// products, then the sum, then runs the binary GCD loop (one step a cycle),
// then steps the divider cell rows, then loads the output register. The
// worst case is set by the GCD loop and the divider rows; special cases
// skip both and go straight to the output register.
// The result register parts the two sides: the next item is accepted while
// a result waits; a stalled receiver holds the result and, once the next
// result is ready, the block stops accepting until the receiver takes one.
// Synchronous reset empties the pipeline and drops any waiting result.
module rational_arith_reduce #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // command, a_num, a_den, b_num, b_den from bit 0 up, zero padded
   input  logic [8*((2+4*OPERAND_WIDTH+7)/8)-1:0] req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // result_num, result_den from bit 0 up, zero padded
   output logic [71:0]                           rsp_tdata,
   // zero_divide
   output logic                                  rsp_tuser
);

   localparam int W  = OPERAND_WIDTH;
   localparam int MW = 2 * OPERAND_WIDTH;
   localparam int KW = $clog2(MW);
   localparam int CW = $clog2(MW + 1);
   localparam int NW = rar_pkg::NUM_OUT_WIDTH;
   localparam int DW = rar_pkg::DEN_OUT_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_SUM, ST_GCD, ST_DIV, ST_FIN
   } state_type;

   function automatic logic [OPERAND_WIDTH-1:0] mag_of(input logic [OPERAND_WIDTH-1:0] v);
      return v[OPERAND_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   state_type      state_ff, state_in;
   logic [1:0]     cmd_ff, cmd_in;
   logic [W-1:0]   an_ff, ad_ff, bn_ff, bd_ff;
   logic [W-1:0]   an_in, ad_in, bn_in, bd_in;
   logic           ans_ff, ads_ff, bns_ff, bds_ff;
   logic           ans_in, ads_in, bns_in, bds_in;
   logic           err_ff, err_in;
   logic [MW-1:0]  pa_ff, pb_ff, pc_ff, pa_in, pb_in, pc_in;
   logic           sa_ff, sb_ff, sc_ff, sa_in, sb_in, sc_in;
   logic           special_ff, special_in;
   logic           neg_ff, neg_in;
   logic [MW-1:0]  nm_ff, dm_ff, nm_in, dm_in;
   logic [MW-1:0]  u_ff, v_ff, u_in, v_in;
   logic [KW-1:0]  k_ff, k_in;
   logic [MW-1:0]  g_ff, g_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [NW-1:0]  rnum_ff, rnum_in;
   logic [DW-1:0]  rden_ff, rden_in;
   logic           rerr_ff, rerr_in;

   rar_pkg::div_ctl_type ctl;
   logic [MW-1:0]  qn, qd;
   logic [64:0]    n_wide, d_wide;
   logic [NW-1:0]  num_mag;
   logic           req_fire;
   logic           gcd_done;
   logic [W-1:0]   in_an, in_ad, in_bn, in_bd;
   logic [W-1:0]   mul_rhs;
   logic           mul_rhs_s;
   logic           t2_s;

   assign in_an = req_tdata[2 +: W];
   assign in_ad = req_tdata[2 + W +: W];
   assign in_bn = req_tdata[2 + 2*W +: W];
   assign in_bd = req_tdata[2 + 3*W +: W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign gcd_done   = (state_ff == ST_GCD) && (u_ff == v_ff);

   assign ctl.load = gcd_done;
   assign ctl.step = (state_ff == ST_DIV);

   assign mul_rhs   = (cmd_ff == rar_pkg::CMD_MUL) ? bn_ff : bd_ff;
   assign mul_rhs_s = (cmd_ff == rar_pkg::CMD_MUL) ? bns_ff : bds_ff;
   assign t2_s      = sb_ff ^ (cmd_ff == rar_pkg::CMD_SUB);

   assign n_wide  = 65'(qn);
   assign d_wide  = 65'(qd);
   assign num_mag = n_wide[NW-1:0];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      ans_in = ans_ff; ads_in = ads_ff; bns_in = bns_ff; bds_in = bds_ff;
      err_in       = err_ff;
      pa_in = pa_ff; pb_in = pb_ff; pc_in = pc_ff;
      sa_in = sa_ff; sb_in = sb_ff; sc_in = sc_ff;
      special_in   = special_ff;
      neg_in       = neg_ff;
      nm_in = nm_ff; dm_in = dm_ff;
      u_in = u_ff; v_in = v_ff; k_in = k_ff; g_in = g_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rnum_in = rnum_ff; rden_in = rden_ff; rerr_in = rerr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in = req_tdata[1:0];
               an_in  = mag_of(in_an);  ans_in = in_an[W-1];
               ad_in  = mag_of(in_ad);  ads_in = in_ad[W-1];
               bn_in  = mag_of(in_bn);  bns_in = in_bn[W-1];
               bd_in  = mag_of(in_bd);  bds_in = in_bd[W-1];
               err_in = (in_ad == '0) || (in_bd == '0) ||
                        ((req_tdata[1:0] == rar_pkg::CMD_DIV) && (in_bn == '0));
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            pa_in = MW'(an_ff) * MW'(mul_rhs);
            pb_in = MW'(ad_ff) * MW'(bn_ff);
            pc_in = MW'(ad_ff) * MW'(bd_ff);
            sa_in = ans_ff ^ mul_rhs_s;
            sb_in = ads_ff ^ bns_ff;
            sc_in = ads_ff ^ bds_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            case (cmd_ff)
               rar_pkg::CMD_MUL: begin
                  nm_in = pa_ff; dm_in = pc_ff; neg_in = sa_ff ^ sc_ff;
               end
               rar_pkg::CMD_DIV: begin
                  nm_in = pa_ff; dm_in = pb_ff; neg_in = sa_ff ^ sb_ff;
               end
               default: begin
                  dm_in = pc_ff;
                  if (sa_ff == t2_s) begin
                     nm_in = pa_ff + pb_ff; neg_in = sa_ff ^ sc_ff;
                  end else if (pa_ff >= pb_ff) begin
                     nm_in = pa_ff - pb_ff; neg_in = sa_ff ^ sc_ff;
                  end else begin
                     nm_in = pb_ff - pa_ff; neg_in = t2_s ^ sc_ff;
                  end
               end
            endcase
            u_in = nm_in;
            v_in = dm_in;
            k_in = '0;
            special_in = err_ff || (nm_in == '0);
            state_in = special_in ? ST_FIN : ST_GCD;
         end
         ST_GCD: begin
            if (gcd_done) begin
               g_in     = u_ff << k_ff;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (u_ff > v_ff) begin
               u_in = (u_ff - v_ff) >> 1;
            end else begin
               v_in = (v_ff - u_ff) >> 1;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MW - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (special_ff) begin
                  rnum_in = '0;
                  rden_in = DW'(1);
                  rerr_in = err_ff;
               end else begin
                  rnum_in = neg_ff ? (NW'(0) - num_mag) : num_mag;
                  rden_in = d_wide[DW-1:0];
                  rerr_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      ans_ff <= ans_in; ads_ff <= ads_in; bns_ff <= bns_in; bds_ff <= bds_in;
      err_ff <= err_in;
      pa_ff <= pa_in; pb_ff <= pb_in; pc_ff <= pc_in;
      sa_ff <= sa_in; sb_ff <= sb_in; sc_ff <= sc_in;
      special_ff <= special_in;
      neg_ff <= neg_in;
      nm_ff <= nm_in; dm_ff <= dm_in;
      u_ff <= u_in; v_ff <= v_in; k_ff <= k_in; g_ff <= g_in;
      cnt_ff <= cnt_in;
      rnum_ff <= rnum_in; rden_ff <= rden_in; rerr_ff <= rerr_in;
   end

   rar_div_row #(.WIDTH(MW)) u_row_num (
      .clock    (clock),
      .ctl      (ctl),
      .dividend (nm_ff),
      .divisor  (g_ff),
      .quotient (qn)
   );

   rar_div_row #(.WIDTH(MW)) u_row_den (
      .clock    (clock),
      .ctl      (ctl),
      .dividend (dm_ff),
      .divisor  (g_ff),
      .quotient (qd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rden_ff, rnum_ff};
   assign rsp_tuser  = rerr_ff;

   a_err_is_zero_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[NW-1:0] == '0) && (rsp_tdata[NW +: DW] == DW'(1)))
      else $error("flagged result is not 0/1");

   a_den_positive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[NW +: DW] != '0)
      else $error("zero denominator delivered");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GCD |-> (u_ff != '0) && (v_ff != '0))
      else $error("gcd operand reached zero");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_MUL)
      else $error("accepted item not started");

endmodule

[tb/rational_arith_reduce_tb.sv]
// Testbench for the rational arithmetic reducer: random and directed fractions, scoreboarded.
`timescale 1ns / 1ps

module rational_arith_reduce_tb;

   localparam int OW = 16;
   localparam int REQ_W = 8 * ((2 + 4 * OW + 7) / 8);

   typedef struct {
      logic [32:0] num;
      logic [31:0] den;
      logic        zdiv;
   } fraction_result_type;

   class fraction_scoreboard;
      fraction_result_type pending[$];
      int errors;
      int checked;

      function logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
         logic [63:0] t;
         while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
         end
         return x;
      endfunction

      // Work the exact result in wide signed arithmetic, then reduce.
      function void note_request(logic [1:0] cmd, logic signed [OW-1:0] an,
                                 logic signed [OW-1:0] ad, logic signed [OW-1:0] bn,
                                 logic signed [OW-1:0] bd);
         fraction_result_type r;
         logic signed [66:0] n, d;
         logic [63:0] nm, dm, g;
         r.num = 0;
         r.den = 1;
         r.zdiv = 0;
         if (ad == 0 || bd == 0 || (cmd == rar_pkg::CMD_DIV && bn == 0)) begin
            r.zdiv = 1;
         end else begin
            case (cmd)
               rar_pkg::CMD_ADD: begin
                  n = 67'(an) * bd + 67'(ad) * bn;
                  d = 67'(ad) * bd;
               end
               rar_pkg::CMD_SUB: begin
                  n = 67'(an) * bd - 67'(ad) * bn;
                  d = 67'(ad) * bd;
               end
               rar_pkg::CMD_MUL: begin
                  n = 67'(an) * bn;
                  d = 67'(ad) * bd;
               end
               default: begin
                  n = 67'(an) * bd;
                  d = 67'(ad) * bn;
               end
            endcase
            if (n != 0) begin
               nm = (n < 0) ? 64'(-n) : 64'(n);
               dm = (d < 0) ? 64'(-d) : 64'(d);
               g = euclid(nm, dm);
               nm = nm / g;
               dm = dm / g;
               r.num = ((n < 0) != (d < 0)) ? 33'(-nm) : 33'(nm);
               r.den = 32'(dm);
            end
         end
         pending.push_back(r);
      endfunction

      task report_mismatch(string msg);
         errors++;
         if (errors <= 50)
            $display("MISMATCH @%0t result %0d: %s", $realtime, checked, msg);
      endtask

      task check_result(logic [71:0] data, logic zdiv);
         fraction_result_type e;
         checked++;
         if (pending.size() == 0) begin
            report_mismatch("result with nothing expected");
            return;
         end
         e = pending.pop_front();
         if (data[32:0] !== e.num)
            report_mismatch($sformatf("numerator %0h, want %0h", data[32:0], e.num));
         if (data[64:33] !== e.den)
            report_mismatch($sformatf("denominator %0h, want %0h", data[64:33], e.den));
         if (data[71:65] !== 7'd0)
            report_mismatch("padding bits not zero");
         if (zdiv !== e.zdiv)
            report_mismatch($sformatf("zero_divide %0b, want %0b", zdiv, e.zdiv));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic rsp_tuser;

   fraction_scoreboard sb = new();
   bit quiet_phase = 0;
   bit stim_done = 0;
   int sent = 0;

   rational_arith_reduce #(.OPERAND_WIDTH(OW)) i_dut (.*);

   initial forever #1 clock = ~clock;

   // Receiver: random stall bursts, none in the quiet phase.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   initial begin
      int stall;
      @(posedge clock);
      forever begin
         @(posedge clock);
         if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(1, 12);
            rsp_tready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1;
      end
   end

   task automatic send_item(logic [1:0] cmd, logic [OW-1:0] an, logic [OW-1:0] ad,
                            logic [OW-1:0] bn, logic [OW-1:0] bd);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= REQ_W'({bd, bn, ad, an, cmd});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(cmd, an, ad, bn, bd);
      sent++;
   endtask

   function automatic logic [OW-1:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return OW'($urandom_range(0, 8)) - OW'(4);
         1: return {1'b1, {(OW-1){1'b0}}};
         2: return {1'b0, {(OW-1){1'b1}}};
         3: return OW'($urandom_range(0, 200)) - OW'(100);
         default: return OW'($urandom());
      endcase
   endfunction

   initial begin
      logic [OW-1:0] mx, mn;
      logic [1:0] c;
      mx = {1'b0, {(OW-1){1'b1}}};
      mn = {1'b1, {(OW-1){1'b0}}};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: extremes, each command, zero denominators, zero divisor, zero result.
      for (int k = 0; k < 4; k++) begin
         c = 2'(k);
         send_item(c, mx, OW'(1), mx, OW'(1));
         send_item(c, mn, mn, mn, OW'(1));
         send_item(c, mn, mx, mx, mn);
      end
      send_item(rar_pkg::CMD_ADD, OW'(3), OW'(0), OW'(1), OW'(2));
      send_item(rar_pkg::CMD_MUL, OW'(3), OW'(2), OW'(1), OW'(0));
      send_item(rar_pkg::CMD_DIV, OW'(3), OW'(2), OW'(0), OW'(5));
      send_item(rar_pkg::CMD_DIV, OW'(0), OW'(2), OW'(0), OW'(-5));
      send_item(rar_pkg::CMD_MUL, OW'(0), OW'(-7), OW'(5), OW'(3));
      send_item(rar_pkg::CMD_SUB, OW'(1), OW'(2), OW'(1), OW'(2));
      send_item(rar_pkg::CMD_ADD, OW'(1), OW'(-2), OW'(1), OW'(2));
      send_item(rar_pkg::CMD_MUL, OW'(-6), OW'(4), OW'(2), OW'(-9));
      send_item(rar_pkg::CMD_DIV, OW'(-1), OW'(-1), OW'(-1), OW'(-1));
      send_item(rar_pkg::CMD_SUB, 16'hffff, 16'haaaa, 16'h5555, 16'hffff);
      // Drain completely once before the random part.
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      for (int i = 0; i < 2000; i++) begin
         if (i == 1800) quiet_phase = 1;
         c = 2'($urandom_range(0, 3));
         send_item(c, pick_operand(), pick_operand(), pick_operand(), pick_operand());
      end
      req_tvalid <= 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Covered %0d items: all four commands, operand extremes,", sent);
      $display("zero denominators, zero divisors and zero results, with stalls on both sides.");
      if (sb.errors == 0)
         $display("rational_arith_reduce_tb OK");
      else
         $display("rational_arith_reduce_tb NOT OK");
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d results pending", sb.pending.size());
      $display("rational_arith_reduce_tb NOT OK");
      $finish;
   end
endmodule
